FILE: src/tmprof_pkg.sv
// ----------------------------------------------------------------------------
// tmprof_pkg
// Types and constants shared by the trapezoidal motion profile modules.
// ----------------------------------------------------------------------------
package tmprof_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_START_POSITION  = 3'd0;
   localparam logic [2:0] CSR_END_POSITION    = 3'd1;
   localparam logic [2:0] CSR_PEAK_SPEED      = 3'd2;
   localparam logic [2:0] CSR_ACCELERATION    = 3'd3;
   localparam logic [2:0] CSR_MOVE_START_TIME = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VV,
      ST_DA,
      ST_CMP,
      ST_DIV,
      ST_QUO,
      ST_SQRT,
      ST_ROOT,
      ST_VP1,
      ST_VP2,
      ST_VP3,
      ST_H1,
      ST_H2,
      ST_H3,
      ST_H4
   } plan_state_type;

   typedef enum logic [2:0] {
      KIND_BEFORE,
      KIND_END,
      KIND_ACC,
      KIND_CRUISE,
      KIND_DEC
   } kind_type;

   // profile breakpoints, times saturated past the 32-bit sample range
   typedef struct packed {
      logic [32:0] ta;      // end of acceleration
      logic [32:0] ta_tc;   // end of cruise
      logic [33:0] t_end;   // end of move
      logic [30:0] vp;      // reached peak speed
      logic [31:0] hta;     // acceleration distance, clamped to move length
   } plan_type;

   // move limits derived from the registers
   typedef struct packed {
      logic [31:0] p0;
      logic [31:0] p1;
      logic [31:0] t0;
      logic [30:0] accel;
      logic [31:0] move_len;
      logic        neg;
   } limits_type;

endpackage

FILE: src/tmprof_planner.sv
// ----------------------------------------------------------------------------
// tmprof_planner
// Sequencer that works out the profile breakpoints from the move limits
// with one shared multiplier, a bit-serial divider and a bit-serial root.
// ----------------------------------------------------------------------------
module tmprof_planner #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [30:0]           accel,
   input  logic [30:0]           speed,
   input  logic [31:0]           move_len,
   output tmprof_pkg::plan_type  plan,
   output logic                  busy
);

   localparam int QW = 32 + 2 * FRACTION_BITS;
   localparam int RW = QW / 2;
   localparam int SW = RW + 3;
   localparam int CW = $clog2(QW + 1);
   localparam int HS = 2 * FRACTION_BITS + 1;

   tmprof_pkg::plan_state_type state_ff, state_in;
   tmprof_pkg::plan_type       plan_ff;

   logic [63:0]    prod_ff, save_ff;
   logic [31:0]    op_x, op_y;
   logic           tri_ff, second_ff;
   logic [QW-1:0]  num_ff, ta_ff, tc_ff;
   logic [31:0]    rem_ff;
   logic [30:0]    den_ff;
   logic [CW-1:0]  cnt_ff;
   logic [RW-1:0]  root_ff;
   logic [SW-1:0]  srem_ff;
   logic [30:0]    vp_ff;

   logic           tri_now;
   logic [32:0]    rem_sh;
   logic           qbit;
   logic [SW-1:0]  srem_sh, trial;
   logic           sbit;
   logic [95:0]    wsum, hval;
   logic           ta_big;
   logic [QW:0]    tatc;
   logic [QW+1:0]  tend;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmprof_pkg::ST_IDLE: state_in = tmprof_pkg::ST_IDLE;
         tmprof_pkg::ST_VV:   state_in = tmprof_pkg::ST_DA;
         tmprof_pkg::ST_DA:   state_in = tmprof_pkg::ST_CMP;
         tmprof_pkg::ST_CMP:  state_in = tmprof_pkg::ST_DIV;
         tmprof_pkg::ST_DIV:
            state_in = (cnt_ff == CW'(1)) ? tmprof_pkg::ST_QUO : tmprof_pkg::ST_DIV;
         tmprof_pkg::ST_QUO: begin
            if (tri_ff)         state_in = tmprof_pkg::ST_SQRT;
            else if (second_ff) state_in = tmprof_pkg::ST_H1;
            else                state_in = tmprof_pkg::ST_DIV;
         end
         tmprof_pkg::ST_SQRT:
            state_in = (cnt_ff == CW'(1)) ? tmprof_pkg::ST_ROOT : tmprof_pkg::ST_SQRT;
         tmprof_pkg::ST_ROOT: state_in = tmprof_pkg::ST_VP1;
         tmprof_pkg::ST_VP1:  state_in = tmprof_pkg::ST_VP2;
         tmprof_pkg::ST_VP2:  state_in = tmprof_pkg::ST_VP3;
         tmprof_pkg::ST_VP3:  state_in = tmprof_pkg::ST_H1;
         tmprof_pkg::ST_H1:   state_in = tmprof_pkg::ST_H2;
         tmprof_pkg::ST_H2:   state_in = tmprof_pkg::ST_H3;
         tmprof_pkg::ST_H3:   state_in = tmprof_pkg::ST_H4;
         tmprof_pkg::ST_H4:   state_in = tmprof_pkg::ST_IDLE;
         default:             state_in = tmprof_pkg::ST_IDLE;
      endcase
      if (start) state_in = tmprof_pkg::ST_VV;
   end

   // multiplier operands
   always_comb begin
      op_x = '0;
      op_y = '0;
      unique case (state_ff)
         tmprof_pkg::ST_VV: begin
            op_x = {1'b0, speed};
            op_y = {1'b0, speed};
         end
         tmprof_pkg::ST_DA: begin
            op_x = move_len;
            op_y = {1'b0, accel};
         end
         tmprof_pkg::ST_VP1, tmprof_pkg::ST_H1: begin
            op_x = {1'b0, accel};
            op_y = ta_ff[31:0];
         end
         tmprof_pkg::ST_VP2: begin
            op_x = {1'b0, accel};
            op_y = 32'(ta_ff >> 32);
         end
         tmprof_pkg::ST_H2: begin
            op_x = prod_ff[31:0];
            op_y = ta_ff[31:0];
         end
         tmprof_pkg::ST_H3: begin
            op_x = save_ff[63:32];
            op_y = ta_ff[31:0];
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
   end

   assign tri_now = save_ff > prod_ff;

   // restoring divide step
   assign rem_sh = {rem_ff, num_ff[QW-1]};
   assign qbit   = rem_sh >= {2'b00, den_ff};

   // root step
   assign srem_sh = {srem_ff[SW-3:0], num_ff[QW-1:QW-2]};
   assign trial   = SW'({root_ff, 2'b01});
   assign sbit    = srem_sh >= trial;

   assign wsum   = {prod_ff, 32'b0} + {32'b0, save_ff};
   assign hval   = wsum >> HS;
   assign ta_big = (ta_ff >> 32) != '0;
   assign tatc   = {1'b0, ta_ff} + {1'b0, tc_ff};
   assign tend   = {1'b0, ta_ff, 1'b0} + {2'b00, tc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmprof_pkg::ST_VV;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_x * op_y;
      unique case (state_ff)
         tmprof_pkg::ST_DA: begin
            save_ff <= prod_ff;
         end
         tmprof_pkg::ST_CMP: begin
            tri_ff    <= tri_now;
            second_ff <= 1'b0;
            num_ff    <= tri_now ? (QW'(move_len) << (2 * FRACTION_BITS))
                                 : (QW'(speed) << FRACTION_BITS);
            den_ff    <= accel;
            rem_ff    <= '0;
            cnt_ff    <= CW'(QW);
         end
         tmprof_pkg::ST_DIV: begin
            num_ff <= {num_ff[QW-2:0], qbit};
            rem_ff <= qbit ? 32'(rem_sh - {2'b00, den_ff}) : rem_sh[31:0];
            cnt_ff <= cnt_ff - CW'(1);
         end
         tmprof_pkg::ST_QUO: begin
            if (tri_ff) begin
               root_ff <= '0;
               srem_ff <= '0;
               cnt_ff  <= CW'(RW);
            end else if (!second_ff) begin
               ta_ff     <= num_ff;
               second_ff <= 1'b1;
               num_ff    <= QW'(move_len) << FRACTION_BITS;
               den_ff    <= speed;
               rem_ff    <= '0;
               cnt_ff    <= CW'(QW);
            end else begin
               tc_ff <= num_ff - ta_ff;
               vp_ff <= speed;
            end
         end
         tmprof_pkg::ST_SQRT: begin
            num_ff  <= num_ff << 2;
            srem_ff <= sbit ? (srem_sh - trial) : srem_sh;
            root_ff <= {root_ff[RW-2:0], sbit};
            cnt_ff  <= cnt_ff - CW'(1);
         end
         tmprof_pkg::ST_ROOT: begin
            ta_ff <= QW'(root_ff);
            tc_ff <= '0;
         end
         tmprof_pkg::ST_VP2, tmprof_pkg::ST_H2, tmprof_pkg::ST_H3: begin
            save_ff <= prod_ff;
         end
         tmprof_pkg::ST_VP3: begin
            vp_ff <= 31'(wsum >> FRACTION_BITS);
         end
         tmprof_pkg::ST_H4: begin
            plan_ff.ta    <= ta_big ? 33'h1_0000_0000 : {1'b0, ta_ff[31:0]};
            plan_ff.ta_tc <= ((tatc >> 32) != '0) ? 33'h1_0000_0000
                                                  : {1'b0, tatc[31:0]};
            plan_ff.t_end <= ((tend >> 34) != '0) ? '1 : tend[33:0];
            plan_ff.vp    <= vp_ff;
            plan_ff.hta   <= (ta_big || ((hval >> 32) != '0) || (hval[31:0] > move_len))
                             ? move_len : hval[31:0];
         end
         default: begin
         end
      endcase
   end

   assign plan = plan_ff;
   assign busy = state_ff != tmprof_pkg::ST_IDLE;

endmodule

FILE: src/tmprof_eval.sv
// ----------------------------------------------------------------------------
// tmprof_eval
// Seven-stage sample pipeline: phase select, multiplies, distance and
// speed clamping, signed output.
// ----------------------------------------------------------------------------
module tmprof_eval #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic [31:0]             sample_time,
   input  tmprof_pkg::limits_type  lim,
   input  tmprof_pkg::plan_type    plan,
   output logic                    out_valid,
   output logic signed [31:0]      position,
   output logic signed [31:0]      velocity
);

   localparam int HS = 2 * FRACTION_BITS + 1;

   logic [6:0] valid_ff;

   // stage 1
   logic        before1_ff;
   logic [31:0] t1_ff;
   // stage 2
   tmprof_pkg::kind_type kind2_ff, kind2_in;
   logic [31:0] x2_ff, x2_in;
   // stage 3
   tmprof_pkg::kind_type kind3_ff;
   logic [31:0] x3_ff;
   logic [62:0] m3_ff;
   // stage 4
   tmprof_pkg::kind_type kind4_ff;
   logic [62:0] m4_ff, ph4_ff;
   logic [63:0] pl4_ff;
   // stage 5
   tmprof_pkg::kind_type kind5_ff;
   logic [32:0] h5_ff, term5_ff;
   // stage 6
   tmprof_pkg::kind_type kind6_ff;
   logic [31:0] dist6_ff, dist6_in;
   logic [30:0] speed6_ff, speed6_in;
   // stage 7
   logic [31:0] pos_ff, pos_in;
   logic [31:0] vel_ff, vel_in;

   logic [30:0] mul_op;
   logic [94:0] sq_sum, sq_sh;
   logic [62:0] term_sh;
   logic [33:0] cruise_sum;

   // phase select
   always_comb begin
      kind2_in = tmprof_pkg::KIND_DEC;
      x2_in    = 32'(plan.t_end - {2'b00, t1_ff});
      if (before1_ff) begin
         kind2_in = tmprof_pkg::KIND_BEFORE;
      end else if ({2'b00, t1_ff} >= plan.t_end) begin
         kind2_in = tmprof_pkg::KIND_END;
      end else if ({1'b0, t1_ff} < plan.ta) begin
         kind2_in = tmprof_pkg::KIND_ACC;
         x2_in    = t1_ff;
      end else if ({1'b0, t1_ff} < plan.ta_tc) begin
         kind2_in = tmprof_pkg::KIND_CRUISE;
         x2_in    = t1_ff - plan.ta[31:0];
      end
   end

   assign mul_op = (kind2_ff == tmprof_pkg::KIND_CRUISE) ? plan.vp : lim.accel;

   // a*x*x from two partial products
   assign sq_sum  = {ph4_ff, 32'b0} + {31'b0, pl4_ff};
   assign sq_sh   = sq_sum >> HS;
   assign term_sh = m4_ff >> FRACTION_BITS;

   assign cruise_sum = {2'b00, plan.hta} + {1'b0, term5_ff};

   always_comb begin
      dist6_in  = '0;
      speed6_in = (term5_ff > {2'b00, plan.vp}) ? plan.vp : term5_ff[30:0];
      unique case (kind5_ff)
         tmprof_pkg::KIND_ACC: begin
            dist6_in = (h5_ff > {1'b0, lim.move_len}) ? lim.move_len : h5_ff[31:0];
         end
         tmprof_pkg::KIND_CRUISE: begin
            dist6_in  = (cruise_sum > {2'b00, lim.move_len}) ? lim.move_len
                                                              : cruise_sum[31:0];
            speed6_in = plan.vp;
         end
         tmprof_pkg::KIND_DEC: begin
            dist6_in = (h5_ff > {1'b0, lim.move_len}) ? '0
                                                       : (lim.move_len - h5_ff[31:0]);
         end
         default: begin
            dist6_in  = '0;
            speed6_in = '0;
         end
      endcase
   end

   always_comb begin
      unique case (kind6_ff)
         tmprof_pkg::KIND_BEFORE: begin
            pos_in = lim.p0;
            vel_in = '0;
         end
         tmprof_pkg::KIND_END: begin
            pos_in = lim.p1;
            vel_in = '0;
         end
         default: begin
            pos_in = lim.neg ? (lim.p0 - dist6_ff) : (lim.p0 + dist6_ff);
            vel_in = lim.neg ? (32'd0 - {1'b0, speed6_ff}) : {1'b0, speed6_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         before1_ff <= sample_time < lim.t0;
         t1_ff      <= sample_time - lim.t0;

         kind2_ff <= kind2_in;
         x2_ff    <= x2_in;

         kind3_ff <= kind2_ff;
         x3_ff    <= x2_ff;
         m3_ff    <= mul_op * x2_ff;

         kind4_ff <= kind3_ff;
         m4_ff    <= m3_ff;
         pl4_ff   <= m3_ff[31:0] * x3_ff;
         ph4_ff   <= m3_ff[62:32] * x3_ff;

         kind5_ff <= kind4_ff;
         h5_ff    <= ((sq_sh >> 32) != '0) ? 33'h1_0000_0000 : {1'b0, sq_sh[31:0]};
         term5_ff <= ((term_sh >> 32) != '0) ? 33'h1_0000_0000 : {1'b0, term_sh[31:0]};

         kind6_ff  <= kind5_ff;
         dist6_ff  <= dist6_in;
         speed6_ff <= speed6_in;

         pos_ff <= pos_in;
         vel_ff <= vel_in;
      end
   end

   assign out_valid = valid_ff[6];
   assign position  = pos_ff;
   assign velocity  = vel_ff;

endmodule

FILE: src/trapezoidal_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// Single-axis trapezoidal / triangular velocity profile evaluator.
// ----------------------------------------------------------------------------
// The block accepts one sample time per clock while req_stall is low and
// returns its position and velocity through a seven-stage pipeline;
// rsp_stall freezes the whole pipeline while rsp_valid is high. After reset
// and after every register write the planner recomputes the profile
// breakpoints with a bit-serial divider and square root, holding req_stall
// high meanwhile.
module trapezoidal_motion_profile #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_sample_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   logic [31:0] start_position_ff, end_position_ff, move_start_time_ff;
   logic [30:0] peak_speed_ff, acceleration_ff;

   logic                   csr_hit;
   logic                   plan_busy;
   logic                   enable;
   logic [30:0]            accel_eff, speed_eff;
   logic signed [32:0]     diff;
   tmprof_pkg::limits_type lim;
   tmprof_pkg::plan_type   plan;

   always_comb begin
      unique case (csr_index)
         tmprof_pkg::CSR_START_POSITION,
         tmprof_pkg::CSR_END_POSITION,
         tmprof_pkg::CSR_PEAK_SPEED,
         tmprof_pkg::CSR_ACCELERATION,
         tmprof_pkg::CSR_MOVE_START_TIME: csr_hit = csr_write_enable;
         default:                         csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_position_ff  <= '0;
         end_position_ff    <= '0;
         peak_speed_ff      <= 31'd65536;
         acceleration_ff    <= 31'd65536;
         move_start_time_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tmprof_pkg::CSR_START_POSITION:  start_position_ff  <= csr_write_data;
            tmprof_pkg::CSR_END_POSITION:    end_position_ff    <= csr_write_data;
            tmprof_pkg::CSR_PEAK_SPEED:      peak_speed_ff      <= csr_write_data[30:0];
            tmprof_pkg::CSR_ACCELERATION:    acceleration_ff    <= csr_write_data[30:0];
            tmprof_pkg::CSR_MOVE_START_TIME: move_start_time_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // zero limits act as the smallest step
   assign accel_eff = (acceleration_ff == '0) ? 31'd1 : acceleration_ff;
   assign speed_eff = (peak_speed_ff == '0) ? 31'd1 : peak_speed_ff;
   assign diff = $signed({end_position_ff[31], end_position_ff})
               - $signed({start_position_ff[31], start_position_ff});

   always_comb begin
      lim.p0       = start_position_ff;
      lim.p1       = end_position_ff;
      lim.t0       = move_start_time_ff;
      lim.accel    = accel_eff;
      lim.neg      = diff[32];
      lim.move_len = diff[32] ? 32'(-diff) : diff[31:0];
   end

   tmprof_planner #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_planner (
      .clock    (clock),
      .reset    (reset),
      .start    (csr_hit),
      .accel    (accel_eff),
      .speed    (speed_eff),
      .move_len (lim.move_len),
      .plan     (plan),
      .busy     (plan_busy)
   );

   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = plan_busy || !enable;

   tmprof_eval #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_eval (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (req_valid && !req_stall),
      .sample_time (req_sample_time),
      .lim         (lim),
      .plan        (plan),
      .out_valid   (rsp_valid),
      .position    (rsp_position),
      .velocity    (rsp_velocity)
   );

`ifndef SYNTH
   // a register write must hold off samples until the plan is redone
   a_write_replans: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (req_stall && plan_busy))
      else $error("register write did not restart planning");

   // a held result must back-pressure the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while result held");

   // a held result transfer keeps its payload
   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_position)
                                    && $stable(rsp_velocity)))
      else $error("held result changed");
`endif

endmodule
